FILE: rtl/pmpt_pkg.sv
// ----------------------------------------------------------------------------
// pmpt_pkg
// Shared types and codes of the polygon mask point test: vertex format,
// request and register codes, and the stage enables handed to the edge lanes.
// ----------------------------------------------------------------------------
package pmpt_pkg;

	// vertex coordinates are signed fixed point of a fixed width
	localparam int VTX_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int COUNT_W = 5;
	localparam int VIDX_W = 4;

	typedef enum logic [0:0] {
		REQ_LOAD  = 1'b0,
		REQ_PIXEL = 1'b1
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERTEX_COUNT = 2'd0,
		CFG_ORIGIN_U     = 2'd1,
		CFG_ORIGIN_V     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VTX_W-1:0] u;
		logic signed [VTX_W-1:0] v;
	} vtx_t;

	// load enables of the lane pipeline stages
	typedef struct packed {
		logic en2;
		logic en3;
		logic en4;
	} pipe_en_t;

endpackage

FILE: rtl/polygon_mask_point_test.sv
// ----------------------------------------------------------------------------
// polygon_mask_point_test
// Even-odd point-in-polygon test over a loadable vertex table.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output handshake stalls it. A load item
// writes one vertex slot in the cycle after its transfer and gives no result;
// a pixel item gives one inside flag from the parity stage. All edges are
// tested at once, one lane with two multipliers per vertex, and the lanes sit
// in a five stage pipeline (input register, differences, products, compare,
// parity), so throughput is set by nothing but the output handshake. A vertex
// count above MAX_VERTICES acts as MAX_VERTICES, a count of zero makes every
// pixel outside, loads into slots at or above MAX_VERTICES are dropped, and a
// point exactly on the crossing column does not count as a crossing.
module polygon_mask_point_test import pmpt_pkg::*; #(
	parameter int MAX_VERTICES = 16,
	parameter int FRAC_BITS    = 8,
	parameter int PIXEL_BITS   = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [VIDX_W-1:0]     vertex_index,
	input  logic signed [VTX_W-1:0] vertex_u,
	input  logic signed [VTX_W-1:0] vertex_v,
	input  logic [PIXEL_BITS-1:0] pixel_u,
	input  logic [PIXEL_BITS-1:0] pixel_v,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  inside_res
);

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int SUM_W = ((PIXEL_BITS + 1 > CFG_DATA_W) ? PIXEL_BITS + 1 : CFG_DATA_W) + 1;
	localparam int PX_W  = SUM_W + FRAC_BITS;

	logic [COUNT_W-1:0]           count_q;
	logic signed [CFG_DATA_W-1:0] origin_u_q;
	logic signed [CFG_DATA_W-1:0] origin_v_q;
	vtx_t                         tab_q [MAX_VERTICES];

	logic                         valid_s1;
	req_type_t                    type_s1;
	logic [VIDX_W-1:0]            idx_s1;
	vtx_t                         vtx_s1;
	logic signed [PX_W-1:0]       px_s1;
	logic signed [PX_W-1:0]       py_s1;
	logic                         valid_s2;
	logic                         valid_s3;
	logic                         valid_s4;
	logic                         valid_s5;
	logic                         inside_s5;

	logic signed [SUM_W-1:0]      su;
	logic signed [SUM_W-1:0]      sv;
	logic [CNT_W-1:0]             n_eff;
	logic [IDX_W-1:0]             last_idx;
	logic                         is_load_s1;
	logic                         s1_leave;
	logic                         en5;
	pipe_en_t                     pen;
	vtx_t                         vj_lane [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]      active;
	logic [MAX_VERTICES-1:0]      cross_s4;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			origin_u_q <= '0;
			origin_v_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_VERTEX_COUNT: count_q    <= cfg_data[COUNT_W-1:0];
				CFG_ORIGIN_U:     origin_u_q <= cfg_data;
				CFG_ORIGIN_V:     origin_v_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective vertex count and wrap vertex of the first edge
	always_comb begin
		if (32'(count_q) > MAX_VERTICES) begin
			n_eff = CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = CNT_W'(count_q);
		end
		last_idx = IDX_W'(n_eff - CNT_W'(1));
	end

	// stage enables, each stage moves when it is empty or the next one moves
	assign en5        = !valid_s5 || out_ready;
	assign pen.en4    = !valid_s4 || en5;
	assign pen.en3    = !valid_s3 || pen.en4;
	assign pen.en2    = !valid_s2 || pen.en3;
	assign is_load_s1 = (type_s1 == REQ_LOAD);
	assign s1_leave   = valid_s1 && (is_load_s1 || pen.en2);
	assign in_ready   = !valid_s1 || s1_leave;

	// pixel offset by origin, scaled to the vertex format
	assign su = SUM_W'(signed'({1'b0, pixel_u})) + SUM_W'(origin_u_q);
	assign sv = SUM_W'(signed'({1'b0, pixel_v})) + SUM_W'(origin_v_q);

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			type_s1  <= req_type_t'(req_type);
			idx_s1   <= vertex_index;
			vtx_s1.u <= vertex_u;
			vtx_s1.v <= vertex_v;
			px_s1    <= PX_W'(su) <<< FRAC_BITS;
			py_s1    <= PX_W'(sv) <<< FRAC_BITS;
		end
	end

	// vertex table, written as a load leaves stage 1
	always_ff @(posedge clk) begin
		if (valid_s1 && is_load_s1 && (32'(idx_s1) < MAX_VERTICES)) begin
			tab_q[IDX_W'(idx_s1)] <= vtx_s1;
		end
	end

	// edge lanes: edge k runs from vertex k-1 (or the last vertex) to vertex k
	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_lane
		if (k == 0) begin : g_wrap
			assign vj_lane[k] = tab_q[last_idx];
		end else begin : g_prev
			assign vj_lane[k] = tab_q[k-1];
		end
		assign active[k] = CNT_W'(k) < n_eff;

		pmpt_lane #(
			.PX_W(PX_W)
		) u_lane (
			.clk      (clk),
			.en       (pen),
			.active   (active[k]),
			.vi       (tab_q[k]),
			.vj       (vj_lane[k]),
			.px       (px_s1),
			.py       (py_s1),
			.cross_s4 (cross_s4[k])
		);
	end

	// valid bits of the lane stages, only pixel items go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (pen.en2) begin
				valid_s2 <= valid_s1 && !is_load_s1;
			end
			if (pen.en3) begin
				valid_s3 <= valid_s2;
			end
			if (pen.en4) begin
				valid_s4 <= valid_s3;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// stage 5: parity of the crossings
	always_ff @(posedge clk) begin
		if (en5) begin
			inside_s5 <= ^cross_s4;
		end
	end

	assign out_valid  = valid_s5;
	assign inside_res = inside_s5;

`ifndef ASSERT_OFF
	a_s1_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with stage 1 empty");

	a_load_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && is_load_s1 |-> in_ready)
		else $error("load item held in stage 1");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && en5 |=> out_valid)
		else $error("finished item lost before output");

	a_no_cross_outside: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && en5 && (cross_s4 == '0) |=> !inside_res)
		else $error("inside flag without any crossing");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(n_eff) <= MAX_VERTICES)
		else $error("effective vertex count beyond table");
`endif

endmodule

FILE: rtl/pmpt_lane.sv
// ----------------------------------------------------------------------------
// pmpt_lane
// One polygon edge of the crossing test: differences, exact
// cross-multiplication and the signed compare, over three register stages.
// ----------------------------------------------------------------------------
module pmpt_lane import pmpt_pkg::*; #(
	parameter int PX_W = 26
) (
	input  logic                   clk,
	input  pipe_en_t               en,
	input  logic                   active,
	input  vtx_t                   vi,
	input  vtx_t                   vj,
	input  logic signed [PX_W-1:0] px,
	input  logic signed [PX_W-1:0] py,
	output logic                   cross_s4
);

	localparam int DX_W   = ((PX_W > VTX_W) ? PX_W : VTX_W) + 1;
	localparam int D_W    = VTX_W + 1;
	localparam int PROD_W = DX_W + D_W;

	logic signed [DX_W-1:0]   dx_s2;
	logic signed [DX_W-1:0]   dy_s2;
	logic signed [D_W-1:0]    d_s2;
	logic signed [D_W-1:0]    e_s2;
	logic                     hit_s2;
	logic signed [PROD_W-1:0] lhs_s3;
	logic signed [PROD_W-1:0] rhs_s3;
	logic                     pos_s3;
	logic                     hit_s3;
	logic                     vi_above;
	logic                     vj_above;

	// edge straddles the ray row
	assign vi_above = DX_W'(vi.v) > DX_W'(py);
	assign vj_above = DX_W'(vj.v) > DX_W'(py);

	// stage 2: differences
	always_ff @(posedge clk) begin
		if (en.en2) begin
			dx_s2  <= DX_W'(px) - DX_W'(vi.u);
			dy_s2  <= DX_W'(py) - DX_W'(vi.v);
			d_s2   <= D_W'(vj.v) - D_W'(vi.v);
			e_s2   <= D_W'(vj.u) - D_W'(vi.u);
			hit_s2 <= active && (vi_above != vj_above);
		end
	end

	// stage 3: both products
	always_ff @(posedge clk) begin
		if (en.en3) begin
			lhs_s3 <= dx_s2 * d_s2;
			rhs_s3 <= e_s2 * dy_s2;
			pos_s3 <= !d_s2[D_W-1] && (d_s2 != '0);
			hit_s3 <= hit_s2;
		end
	end

	// stage 4: strict compare, direction follows the sign of the row difference
	always_ff @(posedge clk) begin
		if (en.en4) begin
			cross_s4 <= hit_s3 && (pos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3));
		end
	end

endmodule

FILE: verif/tb_polygon_mask_point_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_mask_point_test
// Self-checking bench for the even-odd polygon mask point test. Vertex loads
// and pixel tests go in over a valid/ready channel. A local copy of the vertex
// table, count and origins predicts the inside flag of every pixel, and each
// result transfer is compared with the oldest prediction. Directed cases
// cover zero count, edges, corners, extreme origins and vertices. Random
// phases then rebuild a polygon near a random center and test pixels around
// it, mixed with stray loads and pixels. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_polygon_mask_point_test import pmpt_pkg::*; ();

	localparam int CLK_PERIOD    = 10;
	localparam int MAX_VERTICES  = 16;
	localparam int FRAC_BITS     = 8;
	localparam int PIXEL_BITS    = 12;
	localparam int MAX_IDLE      = 18;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASES        = 25;
	localparam int PHASE_ITEMS   = 70;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic                          req_type;
	logic [VIDX_W-1:0]             vertex_index;
	logic signed [VTX_W-1:0]       vertex_u;
	logic signed [VTX_W-1:0]       vertex_v;
	logic [PIXEL_BITS-1:0]         pixel_u;
	logic [PIXEL_BITS-1:0]         pixel_v;
	logic                          out_valid;
	logic                          out_ready;
	logic                          inside_res;

	// local copy of the polygon state
	logic signed [VTX_W-1:0]       vtx_col [MAX_VERTICES];
	logic signed [VTX_W-1:0]       vtx_row [MAX_VERTICES];
	logic [COUNT_W-1:0]            poly_count;
	logic signed [CFG_DATA_W-1:0]  org_u;
	logic signed [CFG_DATA_W-1:0]  org_v;

	// predicted inside flags, oldest first
	logic                          exp_inside_q [$];

	int                            err_count = 0;
	int                            quiet_cycles = 0;
	int                            rx_wait = 0;
	bit                            tx_busy;
	bit                            rx_busy;
	bit                            req_hold;
	bit                            cfg_hold;

	// geometry of the current random phase
	int                            ctr_u;
	int                            ctr_v;
	int                            spread;
	bit                            frac_on;

	polygon_mask_point_test #(
		.MAX_VERTICES(MAX_VERTICES),
		.FRAC_BITS   (FRAC_BITS),
		.PIXEL_BITS  (PIXEL_BITS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.vertex_index(vertex_index),
		.vertex_u    (vertex_u),
		.vertex_v    (vertex_v),
		.pixel_u     (pixel_u),
		.pixel_v     (pixel_v),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.inside_res  (inside_res)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// even-odd count of edge crossings on the ray towards increasing column
	function automatic logic poly_inside(logic [PIXEL_BITS-1:0] pu, logic [PIXEL_BITS-1:0] pv);
		longint px, py, ui, vi, uj, vj, dv, lhs, rhs;
		int     n, j;
		logic   odd;
		n   = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
		odd = 1'b0;
		if (n == 0)
			return 1'b0;
		px = (longint'(pu) + longint'(org_u)) * (longint'(1) << FRAC_BITS);
		py = (longint'(pv) + longint'(org_v)) * (longint'(1) << FRAC_BITS);
		j  = n - 1;
		for (int i = 0; i < n; i++) begin
			ui = longint'(vtx_col[i]);
			vi = longint'(vtx_row[i]);
			uj = longint'(vtx_col[j]);
			vj = longint'(vtx_row[j]);
			// edge straddles the pixel row: compare columns without division
			if ((vi > py) != (vj > py)) begin
				dv  = vj - vi;
				lhs = (px - ui) * dv;
				rhs = (uj - ui) * (py - vi);
				if ((dv > 0) ? (lhs < rhs) : (lhs > rhs))
					odd = ~odd;
			end
			j = i;
		end
		return odd;
	endfunction

	// signed fixed point vertex coordinate from whole and fraction parts
	function automatic logic signed [VTX_W-1:0] fix_pt(int whole, int frac);
		return VTX_W'(whole * (1 << FRAC_BITS) + frac);
	endfunction

	function automatic int idle_draw(bit busy);
		return busy ? int'($urandom_range(0, MAX_IDLE)) : 0;
	endfunction

	// vertex coordinate near the phase center, in origin-shifted space
	function automatic logic signed [VTX_W-1:0] near_vertex(int center, int org);
		int off;
		off = int'($urandom_range(0, 2 * spread)) - spread;
		return fix_pt(center + org + off, frac_on ? int'($urandom_range(0, 255)) : 0);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_origin();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
		else if (sel == 1)
			return CFG_DATA_W'($urandom);
		return CFG_DATA_W'(int'($urandom_range(0, 400)) - 200);
	endfunction

	// one request transfer; valid stays up afterwards so a back-to-back
	// item needs no second assignment in the same step
	task automatic send_req(req_type_t kind, logic [VIDX_W-1:0] idx,
			logic signed [VTX_W-1:0] vu, logic signed [VTX_W-1:0] vv,
			logic [PIXEL_BITS-1:0] pu, logic [PIXEL_BITS-1:0] pv);
		int gap;
		gap = idle_draw(tx_busy);
		if (cfg_hold) begin
			cfg_valid <= 1'b0;
			cfg_hold = 1'b0;
		end
		if (gap > 0) begin
			if (req_hold) begin
				in_valid <= 1'b0;
				req_hold = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= kind;
		vertex_index <= idx;
		vertex_u     <= vu;
		vertex_v     <= vv;
		pixel_u      <= pu;
		pixel_v      <= pv;
		do @(posedge clk); while (!in_ready);
		req_hold = 1'b1;
		// update the local table or predict the flag in transfer order
		if (kind == REQ_LOAD) begin
			vtx_col[idx] = vu;
			vtx_row[idx] = vv;
		end else begin
			exp_inside_q.push_back(poly_inside(pu, pv));
		end
	endtask

	task automatic send_load(int slot, logic signed [VTX_W-1:0] vu, logic signed [VTX_W-1:0] vv);
		send_req(REQ_LOAD, VIDX_W'(slot), vu, vv, PIXEL_BITS'($urandom), PIXEL_BITS'($urandom));
	endtask

	task automatic send_pixel(logic [PIXEL_BITS-1:0] pu, logic [PIXEL_BITS-1:0] pv);
		send_req(REQ_PIXEL, VIDX_W'($urandom), VTX_W'($urandom), VTX_W'($urandom), pu, pv);
	endtask

	// register write transfer, only issued with the block idle
	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_hold = 1'b1;
		case (idx)
			CFG_VERTEX_COUNT: poly_count = data[COUNT_W-1:0];
			CFG_ORIGIN_U:     org_u = data;
			CFG_ORIGIN_V:     org_v = data;
			default: ;
		endcase
	endtask

	// stop sending, wait for every predicted flag, then let the pipe settle
	task automatic drain_results(int settle);
		if (req_hold) begin
			in_valid <= 1'b0;
			req_hold = 1'b0;
		end
		if (cfg_hold) begin
			cfg_valid <= 1'b0;
			cfg_hold = 1'b0;
		end
		while (exp_inside_q.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// count zero after reset: every pixel outside, loads still accepted
	task automatic test_zero_count();
		send_pixel('0, '0);
		send_load(15, 24'sh7FFFFF, 24'sh800000);
		send_pixel('1, '1);
	endtask

	// square in slots 0 to 3, extreme vertex in slot 4
	task automatic test_load_square();
		send_load(0, fix_pt(100, 0), fix_pt(100, 0));
		send_load(1, fix_pt(200, 0), fix_pt(100, 0));
		send_load(2, fix_pt(200, 0), fix_pt(200, 0));
		send_load(3, fix_pt(100, 0), fix_pt(200, 0));
		send_load(4, 24'sh800000, 24'sh7FFFFF);
	endtask

	// interior, exterior, points on edges and corners of the square
	task automatic test_square_edges();
		drain_results(SETTLE_CYCLES);
		cfg_write(CFG_VERTEX_COUNT, 16'd4);
		send_pixel(12'd150, 12'd150);
		send_pixel(12'd50, 12'd150);
		send_pixel(12'd250, 12'd150);
		send_pixel(12'd100, 12'd150);
		send_pixel(12'd200, 12'd150);
		send_pixel(12'd150, 12'd100);
		send_pixel(12'd150, 12'd200);
		send_pixel(12'd100, 12'd100);
		send_pixel(12'd200, 12'd200);
	endtask

	// most negative and positive origins, then an origin that maps the
	// largest pixel column into the square
	task automatic test_origin_extremes();
		drain_results(SETTLE_CYCLES);
		cfg_write(CFG_ORIGIN_U, 16'h8000);
		cfg_write(CFG_ORIGIN_V, 16'h7FFF);
		send_pixel('1, '0);
		drain_results(SETTLE_CYCLES);
		cfg_write(CFG_ORIGIN_U, CFG_DATA_W'(-3945));
		cfg_write(CFG_ORIGIN_V, 16'd150);
		send_pixel('1, '0);
		drain_results(SETTLE_CYCLES);
		cfg_write(CFG_ORIGIN_U, 16'd0);
		cfg_write(CFG_ORIGIN_V, 16'd0);
	endtask

	// triangle from three vertices, then a five vertex shape with a far corner
	task automatic test_fan_counts();
		drain_results(SETTLE_CYCLES);
		cfg_write(CFG_VERTEX_COUNT, 16'd3);
		send_pixel(12'd180, 12'd120);
		send_pixel(12'd120, 12'd180);
		drain_results(SETTLE_CYCLES);
		cfg_write(CFG_VERTEX_COUNT, 16'd5);
		send_pixel(12'd150, 12'd150);
	endtask

	// random phases: fresh polygon near a random center, then pixels around it
	// with stray loads and pixels mixed in
	task automatic test_random_masks();
		int kind, slot, cnt, r;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results(SETTLE_CYCLES);
			tx_busy = $urandom_range(0, 3) != 0;
			rx_busy = $urandom_range(0, 3) != 0;
			cfg_write(CFG_ORIGIN_U, pick_origin());
			cfg_write(CFG_ORIGIN_V, pick_origin());
			// first phases force oversized and zero counts
			r = $urandom_range(0, 9);
			if (ph == 0)
				cnt = 31;
			else if (ph == 1)
				cnt = 17;
			else if (ph == 2)
				cnt = 0;
			else if (r < 8)
				cnt = $urandom_range(3, MAX_VERTICES);
			else if (r == 8)
				cnt = $urandom_range(0, 2);
			else
				cnt = $urandom_range(MAX_VERTICES + 1, 31);
			cfg_write(CFG_VERTEX_COUNT, {11'($urandom), 5'(cnt)});
			ctr_u   = $urandom_range(70, 4025);
			ctr_v   = $urandom_range(70, 4025);
			spread  = $urandom_range(2, 60);
			frac_on = $urandom_range(0, 1);
			for (int s = 0; s < MAX_VERTICES; s++)
				send_load(s, near_vertex(ctr_u, int'(org_u)), near_vertex(ctr_v, int'(org_v)));
			for (int k = 0; k < PHASE_ITEMS - MAX_VERTICES; k++) begin
				kind = $urandom_range(0, 99);
				// occasional hold-off until every result is back
				if (kind == 0)
					drain_results(1);
				if (kind < 12) begin
					send_load($urandom_range(0, MAX_VERTICES - 1),
						near_vertex(ctr_u, int'(org_u)), near_vertex(ctr_v, int'(org_v)));
				end else if (kind < 17) begin
					send_load($urandom_range(0, MAX_VERTICES - 1), VTX_W'($urandom), VTX_W'($urandom));
				end else if (kind < 22) begin
					send_pixel(PIXEL_BITS'($urandom), PIXEL_BITS'($urandom));
				end else if (kind < 32) begin
					// pixel on the whole part of a vertex row and column
					slot = $urandom_range(0, MAX_VERTICES - 1);
					send_pixel(PIXEL_BITS'((vtx_col[slot] >>> FRAC_BITS) - org_u),
						PIXEL_BITS'((vtx_row[slot] >>> FRAC_BITS) - org_v));
				end else begin
					send_pixel(PIXEL_BITS'(ctr_u + int'($urandom_range(0, 2 * spread + 8)) - spread - 4),
						PIXEL_BITS'(ctr_v + int'($urandom_range(0, 2 * spread + 8)) - spread - 4));
				end
			end
		end
	endtask

	// result side ready: random stall after each transfer
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			rx_wait = idle_draw(rx_busy);
			if (rx_wait > 0)
				out_ready <= 1'b0;
		end else if (!out_ready) begin
			if (rx_wait > 0)
				rx_wait--;
			if (rx_wait == 0)
				out_ready <= 1'b1;
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_result
		logic want;
		if (arst_n && out_valid && out_ready) begin
			if (exp_inside_q.size() == 0) begin
				$error("inside_res: unexpected result transfer, actual %0b", inside_res);
				err_count++;
			end else begin
				want = exp_inside_q.pop_front();
				if (inside_res !== want) begin
					$error("inside_res mismatch: expected %0b, actual %0b", want, inside_res);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_polygon_mask_point_test: FAIL");
			$finish;
		end
	end

	// reset, test sequence, final verdict
	initial begin
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_VERTEX_COUNT;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		req_type     <= REQ_LOAD;
		vertex_index <= '0;
		vertex_u     <= '0;
		vertex_v     <= '0;
		pixel_u      <= '0;
		pixel_v      <= '0;
		out_ready    <= 1'b0;
		poly_count = '0;
		org_u      = '0;
		org_v      = '0;
		req_hold   = 1'b0;
		cfg_hold   = 1'b0;
		tx_busy    = 1'b1;
		rx_busy    = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_zero_count();
		test_load_square();
		test_square_edges();
		test_origin_extremes();
		test_fan_counts();
		test_random_masks();
		drain_results(SETTLE_CYCLES);
		if (err_count == 0)
			$display("tb_polygon_mask_point_test: PASS");
		else
			$display("tb_polygon_mask_point_test: FAIL");
		$finish;
	end

endmodule
